>>> hw/rtl/zpc_pkg.sv
// ----------------------------------------------------------------------------
// zpc_pkg
// Shared constants, codes and types of the zero-padded 2D convolution core.
// ----------------------------------------------------------------------------
package zpc_pkg;

  localparam int MAX_ROWS        = 256;
  localparam int MAX_COLS        = 256;
  localparam int MAX_KERNEL_ROWS = 7;
  localparam int MAX_KERNEL_COLS = 7;

  localparam int DIM_W     = 9;
  localparam int KDIM_W    = 3;
  localparam int SAMPLE_W  = 8;
  localparam int COEF_W    = 18;
  localparam int CIDX_W    = 6;
  localparam int OUT_W     = 32;
  localparam int PROD_W    = SAMPLE_W + 1 + COEF_W;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CMP_W     = 16;

  localparam logic [OP_W-1:0] OP_COEF   = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
  localparam logic [OP_W-1:0] OP_DRAIN  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS = 2'd3;

  typedef struct packed {
    logic en;
    logic shift;
  } cell_ctrl_t;

  function automatic logic [CMP_W-1:0] clamp_dim(logic [CMP_W-1:0] v, logic [CMP_W-1:0] hi);
    logic [CMP_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CMP_W'(1);
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/zpc_line.sv
// ----------------------------------------------------------------------------
// zpc_line
// One line of samples: a memory with one write port and a registered read.
// ----------------------------------------------------------------------------
module zpc_line #(
  parameter int DEPTH = zpc_pkg::MAX_COLS,
  parameter int AW    = 8
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 raddr,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [zpc_pkg::SAMPLE_W-1:0]  wdata,
  output logic [zpc_pkg::SAMPLE_W-1:0]  rdata
);

  logic [zpc_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [zpc_pkg::SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/zpc_cell.sv
// ----------------------------------------------------------------------------
// zpc_cell
// One window column: holds a column of samples, passes it to the next cell,
// and forms the masked products and their registered column sum.
// ----------------------------------------------------------------------------
module zpc_cell #(
  parameter int KR   = zpc_pkg::MAX_KERNEL_ROWS,
  parameter int CS_W = zpc_pkg::PROD_W + 3
) (
  input  logic                                clk,
  input  zpc_pkg::cell_ctrl_t                 ctrl,
  input  logic [zpc_pkg::SAMPLE_W-1:0]        vec_i [KR],
  input  logic signed [zpc_pkg::COEF_W-1:0]   coef_i [KR],
  input  logic [KR-1:0]                       mask_i,
  output logic [zpc_pkg::SAMPLE_W-1:0]        vec_o [KR],
  output logic signed [CS_W-1:0]              colsum_o
);

  logic [zpc_pkg::SAMPLE_W-1:0]      data_r [KR];
  logic signed [zpc_pkg::PROD_W-1:0] prod_r [KR];
  logic signed [CS_W-1:0]            colsum_r;
  logic signed [CS_W-1:0]            colsum_nxt;

  always_comb begin
    colsum_nxt = '0;
    for (int k = 0; k < KR; k++) begin
      colsum_nxt = colsum_nxt + CS_W'(prod_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      for (int k = 0; k < KR; k++) begin
        data_r[k] <= vec_i[k];
      end
    end
    if (ctrl.en) begin
      for (int k = 0; k < KR; k++) begin
        if (mask_i[k]) begin
          prod_r[k] <= $signed({1'b0, data_r[k]}) * coef_i[k];
        end else begin
          prod_r[k] <= '0;
        end
      end
      colsum_r <= colsum_nxt;
    end
  end

  assign vec_o    = data_r;
  assign colsum_o = colsum_r;

endmodule

>>> hw/rtl/zero_padded_2d_convolution_core.sv
// ----------------------------------------------------------------------------
// zero_padded_2d_convolution_core
// Same-size 2D convolution with zero padding over a raster sample stream.
// ----------------------------------------------------------------------------
// Write the image and kernel sizes on the cfg channel while the core is idle;
// every such write restarts the plane. Items on the in channel carry a kind
// in in_tuser: coefficient load, sample, or drain tick. Coefficients are
// loaded first; samples stream row-major, one per cycle if not frozen. Each tick
// (sample or drain) shifts one column of the line buffers into a row of
// window cells. Once the lag of the kernel (rows below and columns right of
// the anchor) has filled, every tick yields one item on the out channel, in
// raster order, with out_tlast on the final result of the plane. After the
// last sample, as many drain ticks as the lag flush the remaining results.
// From the tick that completes its window, a result passes the stage 1
// registers, cell samples, products, column sums and output register; the
// core takes one item per cycle while not frozen. When out_tready is low
// with a result held, the whole pipeline freezes and in_tready drops until
// the result is taken. Reset restores the default sizes and clears the
// positions; line memories and coefficients are not cleared.
// ----------------------------------------------------------------------------
module zero_padded_2d_convolution_core #(
  parameter int MAX_ROWS        = zpc_pkg::MAX_ROWS,
  parameter int MAX_COLS        = zpc_pkg::MAX_COLS,
  parameter int MAX_KERNEL_ROWS = zpc_pkg::MAX_KERNEL_ROWS,
  parameter int MAX_KERNEL_COLS = zpc_pkg::MAX_KERNEL_COLS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // sample_value[7:0], coef_index[13:8], coef_value[31:14]
  input  logic [31:0]                       in_tdata,
  // opcode[1:0]
  input  logic [zpc_pkg::OP_W-1:0]          in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // filtered_value[31:0]
  output logic [zpc_pkg::OUT_W-1:0]         out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [zpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [zpc_pkg::DIM_W-1:0]         cfg_data
);

  localparam int CMP_W  = zpc_pkg::CMP_W;
  localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int KT     = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
  localparam int KTW    = (KT > 1) ? $clog2(KT) : 1;
  localparam int LAG_W  = $clog2(MAX_KERNEL_ROWS * MAX_COLS + MAX_KERNEL_COLS + 1);
  localparam int CS_W   = zpc_pkg::PROD_W + $clog2(MAX_KERNEL_ROWS + 1);
  localparam int TOT_W  = CS_W + $clog2(MAX_KERNEL_COLS + 1);
  localparam int KR     = MAX_KERNEL_ROWS;
  localparam int KC     = MAX_KERNEL_COLS;
  localparam int SW     = zpc_pkg::SAMPLE_W;

  // Configuration registers.
  logic [zpc_pkg::DIM_W-1:0]  img_rows_r, img_cols_r;
  logic [zpc_pkg::KDIM_W-1:0] ker_rows_r, ker_cols_r;
  logic                       cfg_wr;

  logic [CMP_W-1:0] rows_c, cols_c, kr_c, kc_c, pr_c, pc_c, lag_c;

  // Position state.
  logic [CW-1:0]    in_col_r, in_col_nxt;
  logic [LAG_W-1:0] cnt_r, cnt_nxt;
  logic [RW-1:0]    oi_r, oi_nxt;
  logic [CW-1:0]    oj_r, oj_nxt;

  // Stage 0 decode.
  logic                    en, acc, tick0, emit0, last0;
  logic [zpc_pkg::OP_W-1:0] op0;
  logic [KR-1:0]           rowok0;
  logic [KC-1:0]           colok0;
  logic [CMP_W-1:0]        arow0, bcol0;

  // Stage 1.
  logic                    s1_v_r, s1_tick_r, s1_emit_r, s1_last_r, s1_coefw_r;
  logic [CW-1:0]           s1_col_r;
  logic [SW-1:0]           s1_sample_r;
  logic [zpc_pkg::CIDX_W-1:0] s1_cidx_r;
  logic signed [zpc_pkg::COEF_W-1:0] s1_cval_r;
  logic [KR-1:0]           s1_rowok_r;
  logic [KC-1:0]           s1_colok_r;

  // Stage 2..4.
  logic                    s2_v_r, s2_emit_r, s2_last_r;
  logic [KR-1:0]           s2_rowok_r;
  logic [KC-1:0]           s2_colok_r;
  logic                    s3_v_r, s3_emit_r, s3_last_r;
  logic                    s4_v_r, s4_emit_r, s4_last_r;

  // Output register.
  logic                    out_valid_r, out_last_r;
  logic [zpc_pkg::OUT_W-1:0] out_data_r;

  // Line buffers and window.
  logic [SW-1:0]           rd_line [KR];
  logic [SW-1:0]           vec1 [KR];
  logic [SW-1:0]           lw_vec_r [KR];
  logic [CW-1:0]           lw_addr_r;
  logic                    lw_v_r;
  logic                    line_we;

  logic [SW-1:0]           cvec [KC][KR];
  logic signed [CS_W-1:0]  colsum [KC];
  logic signed [zpc_pkg::COEF_W-1:0] kt_r [KT];
  logic signed [zpc_pkg::COEF_W-1:0] cell_coef_r [KC][KR];
  zpc_pkg::cell_ctrl_t     cctrl;
  logic signed [TOT_W-1:0] total;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;

  assign rows_c = zpc_pkg::clamp_dim(CMP_W'(img_rows_r), CMP_W'(MAX_ROWS));
  assign cols_c = zpc_pkg::clamp_dim(CMP_W'(img_cols_r), CMP_W'(MAX_COLS));
  assign kr_c   = zpc_pkg::clamp_dim(CMP_W'(ker_rows_r), CMP_W'(MAX_KERNEL_ROWS));
  assign kc_c   = zpc_pkg::clamp_dim(CMP_W'(ker_cols_r), CMP_W'(MAX_KERNEL_COLS));
  assign pr_c   = kr_c >> 1;
  assign pc_c   = kc_c >> 1;
  assign lag_c  = CMP_W'((kr_c - CMP_W'(1) - pr_c) * cols_c + (kc_c - CMP_W'(1) - pc_c));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_rows_r <= zpc_pkg::DIM_W'(256);
      img_cols_r <= zpc_pkg::DIM_W'(256);
      ker_rows_r <= zpc_pkg::KDIM_W'(3);
      ker_cols_r <= zpc_pkg::KDIM_W'(3);
    end else if (cfg_wr) begin
      case (cfg_index)
        zpc_pkg::REG_IMAGE_ROWS:  img_rows_r <= cfg_data;
        zpc_pkg::REG_IMAGE_COLS:  img_cols_r <= cfg_data;
        zpc_pkg::REG_KERNEL_ROWS: ker_rows_r <= cfg_data[zpc_pkg::KDIM_W-1:0];
        zpc_pkg::REG_KERNEL_COLS: ker_cols_r <= cfg_data[zpc_pkg::KDIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign en    = !out_valid_r || out_tready;
  assign in_tready = en;
  assign acc   = in_tvalid && en;
  assign op0   = in_tuser;
  assign tick0 = acc && ((op0 == zpc_pkg::OP_SAMPLE) || (op0 == zpc_pkg::OP_DRAIN));
  assign emit0 = tick0 && (CMP_W'(cnt_r) >= lag_c);
  assign last0 = emit0 && (CMP_W'(oi_r) == rows_c - CMP_W'(1))
                       && (CMP_W'(oj_r) == cols_c - CMP_W'(1));

  assign arow0 = CMP_W'(oi_r) + kr_c - CMP_W'(1) - pr_c;
  assign bcol0 = CMP_W'(oj_r) + kc_c - CMP_W'(1) - pc_c;

  always_comb begin
    for (int k = 0; k < KR; k++) begin
      rowok0[k] = (CMP_W'(k) < kr_c) && (arow0 >= CMP_W'(k))
                  && ((arow0 - CMP_W'(k)) < rows_c);
    end
    for (int d = 0; d < KC; d++) begin
      colok0[d] = (CMP_W'(d) < kc_c) && (bcol0 >= CMP_W'(d))
                  && ((bcol0 - CMP_W'(d)) < cols_c);
    end
  end

  always_comb begin
    in_col_nxt = in_col_r;
    cnt_nxt    = cnt_r;
    oi_nxt     = oi_r;
    oj_nxt     = oj_r;
    if (cfg_wr) begin
      in_col_nxt = '0;
      cnt_nxt    = '0;
      oi_nxt     = '0;
      oj_nxt     = '0;
    end else if (tick0) begin
      if (CMP_W'(in_col_r) == cols_c - CMP_W'(1)) begin
        in_col_nxt = '0;
      end else begin
        in_col_nxt = CW'(in_col_r + 1'b1);
      end
      if (!emit0) begin
        cnt_nxt = LAG_W'(cnt_r + 1'b1);
      end else if (last0) begin
        in_col_nxt = '0;
        cnt_nxt    = '0;
        oi_nxt     = '0;
        oj_nxt     = '0;
      end else if (CMP_W'(oj_r) == cols_c - CMP_W'(1)) begin
        oj_nxt = '0;
        oi_nxt = RW'(oi_r + 1'b1);
      end else begin
        oj_nxt = CW'(oj_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      cnt_r    <= '0;
      oi_r     <= '0;
      oj_r     <= '0;
    end else begin
      in_col_r <= in_col_nxt;
      cnt_r    <= cnt_nxt;
      oi_r     <= oi_nxt;
      oj_r     <= oj_nxt;
    end
  end

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      lw_v_r      <= 1'b0;
    end else if (en) begin
      s1_v_r      <= acc;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      out_valid_r <= s4_v_r && s4_emit_r;
      if (line_we) begin
        lw_v_r <= 1'b1;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_tick_r   <= tick0;
      s1_emit_r   <= emit0;
      s1_last_r   <= last0;
      s1_coefw_r  <= acc && (op0 == zpc_pkg::OP_COEF);
      s1_col_r    <= in_col_r;
      s1_sample_r <= (op0 == zpc_pkg::OP_SAMPLE) ? in_tdata[7:0] : '0;
      s1_cidx_r   <= in_tdata[13:8];
      s1_cval_r   <= $signed(in_tdata[31:14]);
      s1_rowok_r  <= rowok0;
      s1_colok_r  <= colok0;
      s2_emit_r   <= s1_emit_r;
      s2_last_r   <= s1_last_r;
      s2_rowok_r  <= s1_rowok_r;
      s2_colok_r  <= s1_colok_r;
      s3_emit_r   <= s2_emit_r;
      s3_last_r   <= s2_last_r;
      s4_emit_r   <= s3_emit_r;
      s4_last_r   <= s3_last_r;
      out_last_r  <= s4_last_r;
      out_data_r  <= zpc_pkg::OUT_W'(total);
      if (line_we) begin
        lw_addr_r <= s1_col_r;
        lw_vec_r  <= vec1;
      end
      if (s1_v_r && s1_coefw_r && (CMP_W'(s1_cidx_r) < CMP_W'(KT))) begin
        kt_r[KTW'(s1_cidx_r)] <= s1_cval_r;
      end
    end
  end

  // Line buffers: line k holds the row k above the incoming sample.
  assign line_we = en && s1_v_r && s1_tick_r;

  always_comb begin
    vec1[0] = s1_sample_r;
    for (int k = 1; k < KR; k++) begin
      vec1[k] = (lw_v_r && (lw_addr_r == s1_col_r)) ? lw_vec_r[k-1] : rd_line[k];
    end
  end

  assign rd_line[0] = s1_sample_r;

  for (genvar k = 1; k < KR; k++) begin : g_line
    zpc_line #(
      .DEPTH (MAX_COLS),
      .AW    (CW)
    ) u_line (
      .clk   (clk),
      .rd_en (en),
      .raddr (in_col_r),
      .we    (line_we),
      .waddr (s1_col_r),
      .wdata (vec1[k-1]),
      .rdata (rd_line[k])
    );
  end

  // Coefficient for each window position, chosen by the kernel size.
  always_ff @(posedge clk) begin
    for (int d = 0; d < KC; d++) begin
      for (int k = 0; k < KR; k++) begin
        if ((CMP_W'(k) < kr_c) && (CMP_W'(d) < kc_c)) begin
          cell_coef_r[d][k] <= kt_r[KTW'((kr_c - CMP_W'(1) - CMP_W'(k)) * kc_c
                                         + (kc_c - CMP_W'(1) - CMP_W'(d)))];
        end else begin
          cell_coef_r[d][k] <= '0;
        end
      end
    end
  end

  assign cctrl.en    = en;
  assign cctrl.shift = line_we;

  for (genvar d = 0; d < KC; d++) begin : g_cell
    if (d == 0) begin : g_first
      zpc_cell #(
        .KR   (KR),
        .CS_W (CS_W)
      ) u_cell (
        .clk      (clk),
        .ctrl     (cctrl),
        .vec_i    (vec1),
        .coef_i   (cell_coef_r[d]),
        .mask_i   (s2_rowok_r & {KR{s2_colok_r[d]}}),
        .vec_o    (cvec[d]),
        .colsum_o (colsum[d])
      );
    end else begin : g_next
      zpc_cell #(
        .KR   (KR),
        .CS_W (CS_W)
      ) u_cell (
        .clk      (clk),
        .ctrl     (cctrl),
        .vec_i    (cvec[d-1]),
        .coef_i   (cell_coef_r[d]),
        .mask_i   (s2_rowok_r & {KR{s2_colok_r[d]}}),
        .vec_o    (cvec[d]),
        .colsum_o (colsum[d])
      );
    end
  end

  always_comb begin
    total = '0;
    for (int d = 0; d < KC; d++) begin
      total = total + TOT_W'(colsum[d]);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

>>> hw/rtl/zpc_checker.sv
// ----------------------------------------------------------------------------
// zpc_checker
// Port-level checks of the convolution core, bound to the top level.
// ----------------------------------------------------------------------------
module zpc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [31:0]                   in_tdata,
  input logic [zpc_pkg::OP_W-1:0]      in_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [zpc_pkg::OUT_W-1:0]     out_tdata,
  input logic                          out_tlast,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [zpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [zpc_pkg::DIM_W-1:0]     cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result item changed while stalled");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while the pipeline is frozen");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result item after reset");

endmodule

bind zero_padded_2d_convolution_core zpc_checker u_zpc_checker (.*);

>>> tb/tb_zero_padded_2d_convolution_core.sv
// ----------------------------------------------------------------------------
// tb_zero_padded_2d_convolution_core
// Self-checking testbench of the zero-padded 2D convolution core. A class
// predicts every filtered value from the accepted coefficient and sample
// items and checks the out channel in order. Phases sweep image and kernel
// sizes, including clamped and maximum register values, under varied
// sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_zero_padded_2d_convolution_core;
  timeunit 1ns;
  timeprecision 1ps;
  import zpc_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int NUM_TAPS = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
  localparam int NUM_LINES = MAX_KERNEL_ROWS + 1;

  class conv_scoreboard;
    longint kernel_coef[NUM_TAPS];
    logic [SAMPLE_W-1:0] pixel_lines[NUM_LINES*MAX_COLS];
    int unsigned tick_pos, result_pos;
    int unsigned size_reg[4];
    longint sum_queue[$];
    bit last_queue[$];
    int mismatches, results, planes_done;

    function new();
      size_reg[REG_IMAGE_ROWS] = 256;
      size_reg[REG_IMAGE_COLS] = 256;
      size_reg[REG_KERNEL_ROWS] = 3;
      size_reg[REG_KERNEL_COLS] = 3;
    endfunction

    function int unsigned clamp_size(int unsigned v, int unsigned hi);
      return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
      if (idx == REG_IMAGE_ROWS || idx == REG_IMAGE_COLS) size_reg[idx] = v & 9'h1FF;
      else size_reg[idx] = v & 3'h7;
      tick_pos = 0;
      result_pos = 0;
    endfunction

    function void note_input(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] pix,
                             logic [CIDX_W-1:0] ci, logic [COEF_W-1:0] cv);
      int unsigned rows, cols, kr, kc, pr, pc, n, lag, oi, oj, r, c;
      longint sum;
      rows = clamp_size(size_reg[REG_IMAGE_ROWS], MAX_ROWS);
      cols = clamp_size(size_reg[REG_IMAGE_COLS], MAX_COLS);
      kr = clamp_size(size_reg[REG_KERNEL_ROWS], MAX_KERNEL_ROWS);
      kc = clamp_size(size_reg[REG_KERNEL_COLS], MAX_KERNEL_COLS);
      pr = kr / 2;
      pc = kc / 2;
      n = rows * cols;
      lag = (kr - 1 - pr) * cols + (kc - 1 - pc);
      sum = 0;
      if (op == OP_COEF) begin
        if (ci < NUM_TAPS) kernel_coef[ci] = longint'($signed(cv));
        return;
      end
      if (op == OP_UNUSED) return;
      if (tick_pos < n) begin
        r = tick_pos / cols;
        c = tick_pos % cols;
        pixel_lines[(r % NUM_LINES) * MAX_COLS + c] = (op == OP_SAMPLE) ? pix : '0;
      end
      tick_pos++;
      if (tick_pos <= result_pos + lag || result_pos >= n) return;
      oi = result_pos / cols;
      oj = result_pos % cols;
      for (int ki = 0; ki < kr; ki++) begin
        r = oi + ki;
        if (r < pr || r - pr >= rows) continue;
        for (int kj = 0; kj < kc; kj++) begin
          c = oj + kj;
          if (c < pc || c - pc >= cols) continue;
          sum += kernel_coef[ki*kc+kj] *
                 longint'(pixel_lines[((r - pr) % NUM_LINES) * MAX_COLS + c - pc]);
        end
      end
      result_pos++;
      sum_queue.push_back(sum);
      if (result_pos >= n) begin
        last_queue.push_back(1'b1);
        tick_pos = 0;
        result_pos = 0;
        planes_done++;
      end else begin
        last_queue.push_back(1'b0);
      end
    endfunction

    function void check(logic [OUT_W-1:0] data, logic last);
      logic [OUT_W-1:0] want;
      results++;
      if (sum_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h last %b", data, last);
        return;
      end
      want = OUT_W'(sum_queue.pop_front());
      if (want !== data || last_queue[0] !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected %h last %b, got %h last %b",
                   results, want, last_queue[0], data, last);
      end
      void'(last_queue.pop_front());
    endfunction

    function int pending();
      return sum_queue.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;

  conv_scoreboard sb = new();
  int send_idle_pct = 28;
  int recv_idle_pct = 75;
  int ticks_sent = 0;
  int phases = 0;

  zero_padded_2d_convolution_core DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) if (out_tvalid && out_tready) sb.check(out_tdata, out_tlast);

  task automatic send_item(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] pix,
                           logic [CIDX_W-1:0] ci, logic [COEF_W-1:0] cv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = {cv, ci, pix};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(op, pix, ci, cv);
    if (op == OP_SAMPLE || op == OP_DRAIN) ticks_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] v);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    while (sb.pending() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (12) @(negedge clk);
  endtask

  task automatic set_sizes(int unsigned rows, int unsigned cols, int unsigned kr,
                           int unsigned kc);
    int unsigned vals[4];
    int order[4];
    int j, t;
    wait_idle();
    vals[REG_IMAGE_ROWS] = rows;
    vals[REG_IMAGE_COLS] = cols;
    vals[REG_KERNEL_ROWS] = kr;
    vals[REG_KERNEL_COLS] = kc;
    for (int i = 0; i < 4; i++) order[i] = i;
    for (int i = 3; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < 4; i++) write_cfg(CFG_IDX_W'(order[i]), DIM_W'(vals[order[i]]));
    phases++;
  endtask

  task automatic random_item();
    int sel;
    logic [SAMPLE_W-1:0] pix;
    sel = $urandom_range(99);
    pix = ($urandom_range(9) == 0) ? {SAMPLE_W{$urandom_range(1) == 1}} : SAMPLE_W'($urandom);
    if (sel < 80) send_item(OP_SAMPLE, pix, CIDX_W'($urandom), COEF_W'($urandom));
    else if (sel < 90) send_item(OP_DRAIN, pix, CIDX_W'($urandom), COEF_W'($urandom));
    else if (sel < 94) send_item(OP_UNUSED, pix, CIDX_W'($urandom), COEF_W'($urandom));
    else if (sel < 98)
      send_item(OP_COEF, pix, CIDX_W'($urandom_range(NUM_TAPS - 1)), COEF_W'($urandom));
    else
      send_item(OP_COEF, pix, CIDX_W'($urandom_range(63, NUM_TAPS)), COEF_W'($urandom));
  endtask

  task automatic run_planes(int count);
    int goal;
    goal = sb.planes_done + count;
    while (sb.planes_done < goal) random_item();
  endtask

  initial begin
    int guard;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Full kernel table, extremes on the first and last taps.
    for (int i = 0; i < NUM_TAPS; i++) begin
      logic [COEF_W-1:0] cv;
      cv = (i == 0) ? 18'h20000 : (i == NUM_TAPS - 1) ? 18'h1FFFF : COEF_W'($urandom);
      send_item(OP_COEF, SAMPLE_W'($urandom), CIDX_W'(i), cv);
    end
    send_item(OP_COEF, 8'h00, 6'h3F, 18'h3FFFF);
    send_item(OP_UNUSED, 8'hFF, 6'h3F, 18'h3FFFF);

    set_sizes(2, 3, 3, 3);
    send_item(OP_SAMPLE, 8'hFF, '0, '0);
    send_item(OP_SAMPLE, 8'h00, '0, '0);
    send_item(OP_DRAIN, 8'hFF, '0, '0);
    send_item(OP_SAMPLE, 8'hFF, '0, '0);
    send_item(OP_SAMPLE, 8'hFF, '0, '0);
    send_item(OP_SAMPLE, 8'hFF, '0, '0);
    for (int i = 0; i < 6; i++) send_item(OP_SAMPLE, 8'hAA, '0, '0);

    set_sizes(0, 511, 7, 7);
    run_planes(1);
    set_sizes(511, 1, 0, 7);
    run_planes(1);
    set_sizes(3, 4, 7, 0);
    run_planes(2);

    while (ticks_sent < 1150) begin
      if (ticks_sent > 766) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (ticks_sent > 383) begin
        send_idle_pct = 75;
        recv_idle_pct = 28;
      end
      set_sizes(($urandom_range(15) == 0) ? 0 : $urandom_range(1, 6),
                ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 10),
                $urandom_range(7), $urandom_range(7));
      run_planes($urandom_range(1, 2));
    end

    guard = 0;
    while (sb.pending() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
    if (sb.pending() != 0) begin
      $display("%0d expected results never arrived", sb.pending());
      sb.mismatches++;
    end
    $display("covered %0d ticks over %0d size settings, %0d planes, %0d results checked",
             ticks_sent, phases, sb.planes_done, sb.results);
    $display("mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
